@@ design/fpes_pkg.sv @@
// Shared types, command codes, strobe masks and phase hold times for the
// flash program/erase sequencer. No dependencies.
package fpes_pkg;

  localparam int unsigned PHASE_W = 5;  // phase index, up to 18 phases

  // command codes
  localparam logic [2:0] OP_ERASE_MAIN = 3'd0;
  localparam logic [2:0] OP_WRITE_MAIN = 3'd1;
  localparam logic [2:0] OP_WRITE_INFO = 3'd2;
  localparam logic [2:0] OP_READ_INFO  = 3'd3;
  localparam logic [2:0] OP_ERASE_INFO = 3'd4;

  // strobe bits
  localparam logic [7:0] S_XE    = 8'h01;
  localparam logic [7:0] S_YE    = 8'h02;
  localparam logic [7:0] S_SE    = 8'h04;
  localparam logic [7:0] S_ERASE = 8'h08;
  localparam logic [7:0] S_PROG  = 8'h10;
  localparam logic [7:0] S_NVSTR = 8'h20;
  localparam logic [7:0] S_IFREN = 8'h40;
  localparam logic [7:0] S_CON   = 8'h80;

  // hold times in microseconds
  localparam logic [15:0] HOLD_0     = 16'd0;
  localparam logic [15:0] HOLD_1     = 16'd1;
  localparam logic [15:0] HOLD_5     = 16'd5;
  localparam logic [15:0] HOLD_10    = 16'd10;
  localparam logic [15:0] HOLD_20    = 16'd20;
  localparam logic [15:0] HOLD_40    = 16'd40;
  localparam logic [15:0] HOLD_ERASE = 16'd40000;

  // last phase index of each command
  localparam logic [PHASE_W-1:0] LAST_ERASE_MAIN = 5'd17;
  localparam logic [PHASE_W-1:0] LAST_WRITE      = 5'd7;
  localparam logic [PHASE_W-1:0] LAST_READ       = 5'd2;
  localparam logic [PHASE_W-1:0] LAST_ERASE_INFO = 5'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] address;
    logic [31:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  strobes;
    logic [31:0] macro_address;
    logic [31:0] macro_data;
    logic [15:0] hold_us;
    logic        sample_read;
    logic        last;
    logic        rejected;
  } phase_t;

  // strobes and hold of one step of an erase pass on top of a base word
  function automatic logic [23:0] erase_step(input logic [7:0] base,
                                             input logic [1:0] step);
    logic [23:0] r;
    unique case (step)
      2'd0:    r = {base | S_XE | S_ERASE, HOLD_5};
      2'd1:    r = {base | S_XE | S_ERASE | S_NVSTR, HOLD_ERASE};
      2'd2:    r = {base | S_XE | S_NVSTR, HOLD_5};
      default: r = {base, HOLD_1};
    endcase
    return r;
  endfunction

endpackage

@@ design/fpes_if.sv @@
// Valid/ready channel interfaces: command requests in, phase requests out.
// Depends on nothing.
interface fpes_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] address;
  logic [31:0] write_value;

  modport source (output valid, op, address, write_value, input ready);
  modport sink   (input valid, op, address, write_value, output ready);
endinterface

interface fpes_phase_if;
  logic        valid;
  logic        ready;
  logic [7:0]  strobes;
  logic [31:0] macro_address;
  logic [31:0] macro_data;
  logic [15:0] hold_us;
  logic        sample_read;
  logic        last;
  logic        rejected;

  modport source (output valid, strobes, macro_address, macro_data, hold_us,
                  sample_read, last, rejected, input ready);
  modport sink   (input valid, strobes, macro_address, macro_data, hold_us,
                  sample_read, last, rejected, output ready);
endinterface

@@ design/fpes_cmd_stage.sv @@
// Command register and phase counter; takes the next command as the last
// phase of the current one leaves. Depends on fpes_pkg, fpes_if.
module fpes_cmd_stage (
  input  logic                          clk,
  input  logic                          rst,
  fpes_cmd_if.sink                      cmd,
  input  logic                          adv,
  input  logic                          gen_last,
  output fpes_pkg::cmd_t                cur,
  output logic [fpes_pkg::PHASE_W-1:0]  phase_idx,
  output logic                          busy
);

  logic take;
  logic accept;

  assign take      = busy && adv;
  assign cmd.ready = !busy || (take && gen_last);
  assign accept    = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase_idx <= '0;
    end else if (accept) begin
      busy      <= 1'b1;
      phase_idx <= '0;
    end else if (take) begin
      if (gen_last) begin
        busy <= 1'b0;
      end else begin
        phase_idx <= phase_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= '{op: cmd.op, address: cmd.address, write_value: cmd.write_value};
    end
  end

endmodule

@@ design/fpes_phase_gen.sv @@
// Phase decode: strobes, address, data and hold of one phase of a command.
// Pure logic. Depends on fpes_pkg.
module fpes_phase_gen (
  input  fpes_pkg::cmd_t               cur,
  input  logic [fpes_pkg::PHASE_W-1:0] phase_idx,
  output fpes_pkg::phase_t             phase
);

  logic [fpes_pkg::PHASE_W-1:0] q;
  logic [7:0]                   base;
  logic [23:0]                  es;
  logic [31:0]                  sect_addr;
  logic [31:0]                  info_addr;

  assign q         = phase_idx - 1'b1;
  assign sect_addr = {cur.address[31:4], q[3:2], cur.address[1:0]};
  assign info_addr = {12'd0, cur.address[19:12], 8'd0, cur.address[3:0]};

  always_comb begin
    phase = '0;
    base  = '0;
    es    = '0;
    unique case (cur.op)
      fpes_pkg::OP_ERASE_MAIN: begin
        base = fpes_pkg::S_CON;
        es   = fpes_pkg::erase_step(base, q[1:0]);
        if (phase_idx == '0) begin
          phase.strobes       = base;
          phase.macro_address = cur.address;
        end else if (phase_idx == fpes_pkg::LAST_ERASE_MAIN) begin
          // exit keeps the sector 3 address
          phase.macro_address = {cur.address[31:4], 2'd3, cur.address[1:0]};
          phase.last          = 1'b1;
        end else begin
          phase.strobes       = es[23:16];
          phase.hold_us       = es[15:0];
          phase.macro_address = sect_addr;
        end
      end
      fpes_pkg::OP_WRITE_MAIN, fpes_pkg::OP_WRITE_INFO: begin
        base = (cur.op == fpes_pkg::OP_WRITE_INFO) ?
               (fpes_pkg::S_CON | fpes_pkg::S_IFREN) : fpes_pkg::S_CON;
        phase.macro_address = cur.address;
        phase.macro_data    = cur.write_value;
        unique case (phase_idx[2:0])
          3'd0: phase.strobes = base;
          3'd1: begin
            phase.strobes = base | fpes_pkg::S_XE | fpes_pkg::S_PROG;
            phase.hold_us = fpes_pkg::HOLD_5;
          end
          3'd2: begin
            phase.strobes = base | fpes_pkg::S_XE | fpes_pkg::S_PROG |
                            fpes_pkg::S_NVSTR;
            phase.hold_us = fpes_pkg::HOLD_10;
          end
          3'd3: begin
            phase.strobes = base | fpes_pkg::S_XE | fpes_pkg::S_PROG |
                            fpes_pkg::S_NVSTR | fpes_pkg::S_YE;
            phase.hold_us = fpes_pkg::HOLD_40;
          end
          3'd4: begin
            phase.strobes = base | fpes_pkg::S_XE | fpes_pkg::S_PROG |
                            fpes_pkg::S_NVSTR;
            phase.hold_us = (cur.op == fpes_pkg::OP_WRITE_INFO) ?
                            fpes_pkg::HOLD_20 : fpes_pkg::HOLD_1;
          end
          3'd5: begin
            phase.strobes = base | fpes_pkg::S_XE | fpes_pkg::S_NVSTR;
            phase.hold_us = fpes_pkg::HOLD_5;
          end
          3'd6: begin
            phase.strobes = base;
            phase.hold_us = fpes_pkg::HOLD_1;
          end
          default: phase.last = 1'b1;
        endcase
      end
      fpes_pkg::OP_READ_INFO: begin
        base = fpes_pkg::S_CON | fpes_pkg::S_IFREN;
        phase.macro_address = cur.address;
        if (phase_idx == '0) begin
          phase.strobes = base;
        end else if (phase_idx == fpes_pkg::LAST_READ) begin
          phase.last = 1'b1;
        end else begin
          phase.strobes     = base | fpes_pkg::S_XE | fpes_pkg::S_YE |
                              fpes_pkg::S_SE;
          phase.hold_us     = fpes_pkg::HOLD_1;
          phase.sample_read = 1'b1;
        end
      end
      fpes_pkg::OP_ERASE_INFO: begin
        base = fpes_pkg::S_CON | fpes_pkg::S_IFREN;
        es   = fpes_pkg::erase_step(base, q[1:0]);
        if (cur.address[1:0] != 2'b00) begin
          // misaligned word: single refused phase
          phase.last     = 1'b1;
          phase.rejected = 1'b1;
        end else if (phase_idx == '0) begin
          phase.strobes       = base;
          phase.macro_address = info_addr;
        end else if (phase_idx == fpes_pkg::LAST_ERASE_INFO) begin
          phase.strobes       = fpes_pkg::S_IFREN;
          phase.macro_address = info_addr;
          phase.last          = 1'b1;
        end else begin
          phase.strobes       = es[23:16];
          phase.hold_us       = es[15:0];
          phase.macro_address = info_addr;
        end
      end
      default: begin
        phase.last     = 1'b1;
        phase.rejected = 1'b1;
      end
    endcase
  end

endmodule

@@ design/fpes_out_stage.sv @@
// Phase output register; loads a new phase while a command is busy and the
// register is empty or being drained. Depends on fpes_pkg, fpes_if.
module fpes_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             busy,
  input  fpes_pkg::phase_t next,
  output logic             adv,
  fpes_phase_if.source     phase
);

  fpes_pkg::phase_t held;

  assign adv = busy && (!phase.valid || phase.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase.valid <= 1'b0;
    end else if (adv) begin
      phase.valid <= 1'b1;
    end else if (phase.ready) begin
      phase.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      held <= next;
    end
  end

  assign phase.strobes       = held.strobes;
  assign phase.macro_address = held.macro_address;
  assign phase.macro_data    = held.macro_data;
  assign phase.hold_us       = held.hold_us;
  assign phase.sample_read   = held.sample_read;
  assign phase.last          = held.last;
  assign phase.rejected      = held.rejected;

endmodule

@@ design/flash_program_erase_sequencer_top.sv @@
// Flash program/erase sequencer top: command register, phase decode, phase
// output register. Depends on fpes_pkg, fpes_if and the three stages.
//
//   port    dir  payload                                         handshake
//   cmd     in   op, address, write_value                        valid/ready
//   phase   out  strobes, macro_address, macro_data, hold_us,    valid/ready
//                sample_read, last, rejected
//
// One phase request leaves per cycle while a command is in progress and phase
// is not stalled; a command issues 18 phases (main erase), 8 (writes), 6
// (info erase), 3 (info read) or 1 (refused), set by the phase counter in the
// command register. The next command is taken in the cycle its predecessor's
// last phase enters the output register. Reset (rst, synchronous) empties both
// registers. A stall on phase holds the counter and the output register.
module flash_program_erase_sequencer_top (
  input  logic         clk,
  input  logic         rst,
  fpes_cmd_if.sink     cmd,
  fpes_phase_if.source phase
);

  fpes_pkg::cmd_t               cur;
  fpes_pkg::phase_t             next;
  logic [fpes_pkg::PHASE_W-1:0] phase_idx;
  logic                         busy;
  logic                         adv;

  fpes_cmd_stage u_cmd (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .adv       (adv),
    .gen_last  (next.last),
    .cur       (cur),
    .phase_idx (phase_idx),
    .busy      (busy)
  );

  fpes_phase_gen u_gen (
    .cur       (cur),
    .phase_idx (phase_idx),
    .phase     (next)
  );

  fpes_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .busy  (busy),
    .next  (next),
    .adv   (adv),
    .phase (phase)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for flash_program_erase_sequencer_top: drives command
// requests, predicts each phase run and checks it. Needs fpes_pkg, fpes_if.
module testbench;
  import fpes_pkg::*;

  // op codes the block has to refuse
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
  localparam int unsigned RANDOM_CMDS = 410;
  localparam int unsigned CALM_FROM   = 360;

  class phase_plan;
    phase_t due_phases[$];
    int unsigned errors;

    function void push(logic [7:0] s, logic [31:0] a, logic [31:0] d, logic [15:0] h,
                       logic samp, logic lst, logic rej);
      phase_t p;
      p = '{strobes: s, macro_address: a, macro_data: d, hold_us: h,
            sample_read: samp, last: lst, rejected: rej};
      due_phases.push_back(p);
    endfunction

    function void erase_pass(logic [7:0] base, logic [31:0] a);
      push(base | S_XE | S_ERASE, a, '0, HOLD_5, 1'b0, 1'b0, 1'b0);
      push(base | S_XE | S_ERASE | S_NVSTR, a, '0, HOLD_ERASE, 1'b0, 1'b0, 1'b0);
      push(base | S_XE | S_NVSTR, a, '0, HOLD_5, 1'b0, 1'b0, 1'b0);
      push(base, a, '0, HOLD_1, 1'b0, 1'b0, 1'b0);
    endfunction

    function void program_word(logic [7:0] base, logic [31:0] a, logic [31:0] d,
                               logic [15:0] ye_off_hold);
      push(base, a, d, HOLD_0, 1'b0, 1'b0, 1'b0);
      push(base | S_XE | S_PROG, a, d, HOLD_5, 1'b0, 1'b0, 1'b0);
      push(base | S_XE | S_PROG | S_NVSTR, a, d, HOLD_10, 1'b0, 1'b0, 1'b0);
      push(base | S_XE | S_PROG | S_NVSTR | S_YE, a, d, HOLD_40, 1'b0, 1'b0, 1'b0);
      push(base | S_XE | S_PROG | S_NVSTR, a, d, ye_off_hold, 1'b0, 1'b0, 1'b0);
      push(base | S_XE | S_NVSTR, a, d, HOLD_5, 1'b0, 1'b0, 1'b0);
      push(base, a, d, HOLD_1, 1'b0, 1'b0, 1'b0);
      push('0, a, d, HOLD_0, 1'b0, 1'b1, 1'b0);
    endfunction

    // expected phase run of one accepted command
    function void take_command(cmd_t c);
      logic [31:0] a;
      case (c.op)
        OP_ERASE_MAIN: begin
          a = c.address;
          push(S_CON, a, '0, HOLD_0, 1'b0, 1'b0, 1'b0);
          for (int i = 0; i < 4; i++) begin
            a = {c.address[31:4], 2'(i), c.address[1:0]};
            erase_pass(S_CON, a);
          end
          // exit keeps the sector 3 address
          push('0, a, '0, HOLD_0, 1'b0, 1'b1, 1'b0);
        end
        OP_WRITE_MAIN: program_word(S_CON, c.address, c.write_value, HOLD_1);
        OP_WRITE_INFO: program_word(S_CON | S_IFREN, c.address, c.write_value, HOLD_20);
        OP_READ_INFO: begin
          push(S_CON | S_IFREN, c.address, '0, HOLD_0, 1'b0, 1'b0, 1'b0);
          push(S_CON | S_IFREN | S_XE | S_YE | S_SE, c.address, '0, HOLD_1,
               1'b1, 1'b0, 1'b0);
          push('0, c.address, '0, HOLD_0, 1'b0, 1'b1, 1'b0);
        end
        OP_ERASE_INFO: begin
          if (c.address[1:0] != 2'b00) begin
            push('0, '0, '0, HOLD_0, 1'b0, 1'b1, 1'b1);
          end else begin
            a = {12'h000, c.address[19:12], 8'h00, c.address[3:0]};
            push(S_CON | S_IFREN, a, '0, HOLD_0, 1'b0, 1'b0, 1'b0);
            erase_pass(S_CON | S_IFREN, a);
            // exit drops con only
            push(S_IFREN, a, '0, HOLD_0, 1'b0, 1'b1, 1'b0);
          end
        end
        default: push('0, '0, '0, HOLD_0, 1'b0, 1'b1, 1'b1);
      endcase
    endfunction

    function void match_phase(phase_t got);
      phase_t exp;
      if (due_phases.size() == 0) begin
        $error("phase request with nothing pending: %p", got);
        errors++;
        return;
      end
      exp = due_phases.pop_front();
      if (got.strobes !== exp.strobes) begin
        $error("strobes: expected %h, got %h", exp.strobes, got.strobes);
        errors++;
      end
      if (got.macro_address !== exp.macro_address) begin
        $error("macro_address: expected %h, got %h", exp.macro_address, got.macro_address);
        errors++;
      end
      if (got.macro_data !== exp.macro_data) begin
        $error("macro_data: expected %h, got %h", exp.macro_data, got.macro_data);
        errors++;
      end
      if (got.hold_us !== exp.hold_us) begin
        $error("hold_us: expected %0d, got %0d", exp.hold_us, got.hold_us);
        errors++;
      end
      if (got.sample_read !== exp.sample_read) begin
        $error("sample_read: expected %b, got %b", exp.sample_read, got.sample_read);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %b, got %b", exp.last, got.last);
        errors++;
      end
      if (got.rejected !== exp.rejected) begin
        $error("rejected: expected %b, got %b", exp.rejected, got.rejected);
        errors++;
      end
    endfunction
  endclass

  bit clk;
  logic rst;
  bit no_stalls;
  phase_plan plan;

  fpes_cmd_if   cmd_ch();
  fpes_phase_if phase_ch();

  flash_program_erase_sequencer_top dut (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_ch),
    .phase(phase_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cmd_t mk(logic [2:0] op, logic [31:0] a, logic [31:0] d);
    cmd_t c;
    c.op = op;
    c.address = a;
    c.write_value = d;
    return c;
  endfunction

  // entered at a falling edge, leaves at the falling edge after acceptance
  task automatic send_cmd(input cmd_t c);
    int gap;
    if (!no_stalls && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      cmd_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid       = 1'b1;
    cmd_ch.op          = c.op;
    cmd_ch.address     = c.address;
    cmd_ch.write_value = c.write_value;
    do @(posedge clk); while (!cmd_ch.ready);
    plan.take_command(c);
    @(negedge clk);
  endtask

  // phase sink with bursty back-pressure
  initial begin
    int stall_left;
    phase_t got;
    stall_left = 0;
    phase_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        phase_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        phase_ch.ready = 1'b0;
        stall_left--;
      end else if (!no_stalls && $urandom_range(0, 5) == 0) begin
        phase_ch.ready = 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        phase_ch.ready = 1'b1;
      end
      @(posedge clk);
      if (!rst && phase_ch.valid && phase_ch.ready) begin
        got = '{strobes: phase_ch.strobes, macro_address: phase_ch.macro_address,
                macro_data: phase_ch.macro_data, hold_us: phase_ch.hold_us,
                sample_read: phase_ch.sample_read, last: phase_ch.last,
                rejected: phase_ch.rejected};
        plan.match_phase(got);
      end
    end
  end

  initial begin
    cmd_t directed[$];
    cmd_t c;
    int pick;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.op = '0;
    cmd_ch.address = '0;
    cmd_ch.write_value = '0;
    plan = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed.push_back(mk(OP_ERASE_MAIN, 32'h0000_0000, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_ERASE_MAIN, 32'hFFFF_FFFF, 32'h0000_0000));
    directed.push_back(mk(OP_WRITE_MAIN, 32'h0000_0000, 32'h0000_0000));
    directed.push_back(mk(OP_WRITE_MAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_WRITE_MAIN, 32'h1234_5678, 32'hA5A5_5A5A));
    directed.push_back(mk(OP_WRITE_INFO, 32'h0000_0000, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_WRITE_INFO, 32'hFFFF_FFFF, 32'h0000_0000));
    directed.push_back(mk(OP_READ_INFO,  32'h0000_0000, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_READ_INFO,  32'hFFFF_FFFF, 32'h0000_0000));
    // info erase, aligned low nibble 0, 4, 8, C
    directed.push_back(mk(OP_ERASE_INFO, 32'hFFFF_FFF0, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_ERASE_INFO, 32'h000F_F004, 32'h0000_0000));
    directed.push_back(mk(OP_ERASE_INFO, 32'h1234_5678, 32'h0000_0000));
    directed.push_back(mk(OP_ERASE_INFO, 32'hFFFF_FFFC, 32'h0000_0000));
    // info erase, misaligned low nibble
    directed.push_back(mk(OP_ERASE_INFO, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_ERASE_INFO, 32'h0000_0001, 32'h0000_0000));
    directed.push_back(mk(OP_ERASE_INFO, 32'h0000_0002, 32'h0000_0000));
    directed.push_back(mk(OP_ERASE_INFO, 32'hABCD_E003, 32'h0000_0000));
    // unknown ops
    directed.push_back(mk(OP_FIRST_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(mk(OP_FIRST_UNUSED + 3'd1, 32'h0000_0000, 32'h0000_0000));
    directed.push_back(mk(OP_LAST_UNUSED, 32'h5555_AAAA, 32'hAAAA_5555));
    foreach (directed[i]) send_cmd(directed[i]);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i == CALM_FROM) no_stalls = 1'b1;
      pick = $urandom_range(0, 99);
      c.address = $urandom();
      c.write_value = $urandom();
      if (pick < 18)      c.op = OP_ERASE_MAIN;
      else if (pick < 40) c.op = OP_WRITE_MAIN;
      else if (pick < 60) c.op = OP_WRITE_INFO;
      else if (pick < 75) c.op = OP_READ_INFO;
      else if (pick < 94) c.op = OP_ERASE_INFO;
      else                c.op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      // mostly aligned info erases so the full run gets exercised
      if (c.op == OP_ERASE_INFO && $urandom_range(0, 4) != 0) c.address[1:0] = 2'b00;
      send_cmd(c);
    end
    cmd_ch.valid = 1'b0;

    while (plan.due_phases.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (plan.due_phases.size() == 0 && plan.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
